/* rtl/core/msdwg_pkg.sv */
// Package for the multi-shape DAC waveform generator.
// Holds widths, register indexes, shape codes, limits and the cosine table function.
// No dependencies.
`default_nettype none
package msdwg_pkg;

  localparam int MAX_POINTS_DEF      = 1024;
  localparam int COMPONENTS_DEF      = 3;
  localparam int COS_TABLE_DEPTH_DEF = 1024;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;
  localparam int PERIOD_W   = 11;
  localparam int CMP_W      = 17;
  localparam int CODE_W     = 12;
  localparam int RAW_W      = 17;
  localparam int WSUM_W     = 18;
  localparam int ACC_W      = 36;

  localparam int DIV_NUM_W = 35;
  localparam int DIV_DEN_W = 18;
  localparam int DIV_Q_W   = 17;

  localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_POINTS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TURN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_A     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_B     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_C     = 3'd7;

  localparam logic [1:0] SHAPE_COS = 2'd0;
  localparam logic [1:0] SHAPE_TRI = 2'd1;
  localparam logic [1:0] SHAPE_SQR = 2'd2;
  localparam logic [1:0] SHAPE_SAW = 2'd3;
  localparam logic [2:0] WAVE_MIX  = 3'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd100;
  localparam logic [15:0]         AMP_RESET    = 16'd26214;

  localparam logic [CODE_W-1:0] CODE_MIN = 12'd95;
  localparam logic [CODE_W-1:0] CODE_MAX = 12'd4000;
  localparam logic [CODE_W-1:0] CODE_MID = 12'd2048;
  localparam logic [WSUM_W-1:0] WSUM_MIN = 18'd33;

  localparam longint unsigned HALF_PI_Q28 = 64'd421657428;

  function automatic logic [15:0] cos_entry(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    longint unsigned res;
    x2   = (x * x) >> 28;
    term = 64'd1 << 28;
    sum  = longint'(term);
    term = ((term * x2) >> 28) / 2;   sum = sum - longint'(term);
    term = ((term * x2) >> 28) / 12;  sum = sum + longint'(term);
    term = ((term * x2) >> 28) / 30;  sum = sum - longint'(term);
    term = ((term * x2) >> 28) / 56;  sum = sum + longint'(term);
    term = ((term * x2) >> 28) / 90;  sum = sum - longint'(term);
    term = ((term * x2) >> 28) / 132; sum = sum + longint'(term);
    term = ((term * x2) >> 28) / 182; sum = sum - longint'(term);
    term = ((term * x2) >> 28) / 240; sum = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    res = (longint'(sum) + 4096) >> 13;
    return res[15:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/msdwg_if.sv */
// Valid/ready channel interfaces for the waveform generator.
// Depends on nothing.
`default_nettype none
interface msdwg_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface msdwg_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] dac_code;
  logic        period_end;
  modport source (output valid, output dac_code, output period_end, input ready);
  modport sink (input valid, input dac_code, input period_end, output ready);
endinterface
`default_nettype wire

/* rtl/core/msdwg_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on msdwg_pkg.
`default_nettype none
module msdwg_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [msdwg_pkg::DIV_NUM_W-1:0] num_i,
  input  wire logic [msdwg_pkg::DIV_DEN_W-1:0] den_i,
  output logic                                done_o,
  output logic [msdwg_pkg::DIV_Q_W-1:0]       quo_o,
  output logic                                rem_nz_o
);
  import msdwg_pkg::*;

  localparam int CNT_W = $clog2(DIV_Q_W + 1);

  logic [DIV_DEN_W:0]   rem_q, rem_d;
  logic [DIV_Q_W-1:0]   low_q, low_d;
  logic [DIV_Q_W-1:0]   quo_q, quo_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [DIV_DEN_W+1:0] trial;
  logic                 ge;

  always_comb begin
    trial  = {rem_q, low_q[DIV_Q_W-1]};
    ge     = trial >= {2'b00, den_q};
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = {1'b0, num_i[DIV_NUM_W-1:DIV_Q_W]};
      low_d = num_i[DIV_Q_W-1:0];
      den_d = den_i;
      cnt_d = CNT_W'(DIV_Q_W);
    end else if (cnt_q != '0) begin
      rem_d = ge ? (DIV_DEN_W+1)'(trial - {2'b00, den_q}) : trial[DIV_DEN_W:0];
      low_d = {low_q[DIV_Q_W-2:0], 1'b0};
      quo_d = {quo_q[DIV_Q_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o   = done_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = (rem_q != '0);

endmodule
`default_nettype wire

/* rtl/core/multi_shape_dac_waveform_generator.sv */
// Top level of the multi-shape DAC waveform generator: registers, sequencer, shape logic.
// Depends on msdwg_pkg, msdwg_if and msdwg_div.
//
// Each input transaction is one update tick and yields one output transaction with a
// 12-bit DAC code. The block takes one tick at a time and accepts no new tick until the
// code of the last one is registered for output. The shared 17-step divider is
// used once for the turn fraction and once more for the composite weight normalization;
// each composite part adds a pass through the multiply, address, table-read, shape and
// weight states. A finished code waits in the output register while the next tick is taken.
`default_nettype none
module multi_shape_dac_waveform_generator #(
  parameter int MAX_POINTS      = msdwg_pkg::MAX_POINTS_DEF,
  parameter int COMPONENTS      = msdwg_pkg::COMPONENTS_DEF,
  parameter int COS_TABLE_DEPTH = msdwg_pkg::COS_TABLE_DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [msdwg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [msdwg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  msdwg_in_if.sink                             in_i,
  msdwg_out_if.source                          out_o
);
  import msdwg_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int POS_W = $clog2(COS_TABLE_DEPTH + 1);
  localparam int PP_W  = 14 + POS_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_UDIV  = 4'd1;
  localparam logic [3:0] ST_CMUL  = 4'd2;
  localparam logic [3:0] ST_ADDR  = 4'd3;
  localparam logic [3:0] ST_ROM   = 4'd4;
  localparam logic [3:0] ST_RAW   = 4'd5;
  localparam logic [3:0] ST_WMUL  = 4'd6;
  localparam logic [3:0] ST_CFIN  = 4'd7;
  localparam logic [3:0] ST_CDIV  = 4'd8;
  localparam logic [3:0] ST_SCALE = 4'd9;
  localparam logic [3:0] ST_CODE  = 4'd10;

  logic [2:0]          wave_type_q;
  logic [PERIOD_W-1:0] period_q;
  logic [15:0]         amp_q;
  logic [15:0]         phase_q;
  logic [1:0]          count_q;
  logic [CFG_DATA_W-1:0] comp_a_q, comp_b_q, comp_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_type_q <= '0;
      period_q    <= PERIOD_RESET;
      amp_q       <= AMP_RESET;
      phase_q     <= '0;
      count_q     <= '0;
      comp_a_q    <= '0;
      comp_b_q    <= '0;
      comp_c_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WAVE_TYPE:       wave_type_q <= cfg_data_i[2:0];
        REG_PERIOD_POINTS:   period_q    <= cfg_data_i[PERIOD_W-1:0];
        REG_AMPLITUDE:       amp_q       <= cfg_data_i[15:0];
        REG_PHASE_TURN:      phase_q     <= cfg_data_i[15:0];
        REG_COMPONENT_COUNT: count_q     <= cfg_data_i[1:0];
        REG_COMPONENT_A:     comp_a_q    <= cfg_data_i;
        REG_COMPONENT_B:     comp_b_q    <= cfg_data_i;
        REG_COMPONENT_C:     comp_c_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [15:0] cos_rom [COS_TABLE_DEPTH+1];
  for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_cos
    localparam longint unsigned XQ = (longint'(k) * HALF_PI_Q28) / COS_TABLE_DEPTH;
    assign cos_rom[k] = cos_entry(XQ);
  end

  logic [3:0]          state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic [CMP_W-1:0]    p_q, p_d;
  logic [15:0]         u_q, u_d;
  logic [1:0]          comp_q, comp_d;
  logic [1:0]          shape_q, shape_d;
  logic [15:0]         uc_q, uc_d;
  logic [1:0]          quad_q, quad_d;
  logic [POS_W-1:0]    addr_q, addr_d;
  logic [15:0]         tdata_q, tdata_d;
  logic signed [RAW_W-1:0] raw_q, raw_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [WSUM_W-1:0]   wsum_q, wsum_d;
  logic signed [33:0]  m1_q, m1_d;
  logic                ovalid_q, ovalid_d;
  logic [CODE_W-1:0]   ocode_q, ocode_d;
  logic                oend_q, oend_d;

  logic                  div_start;
  logic [DIV_NUM_W-1:0]  div_num;
  logic [DIV_DEN_W-1:0]  div_den;
  logic                  div_done;
  logic [DIV_Q_W-1:0]    div_quo;
  logic                  div_rem_nz;

  msdwg_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (div_num),
    .den_i    (div_den),
    .done_o   (div_done),
    .quo_o    (div_quo),
    .rem_nz_o (div_rem_nz)
  );

  logic [CMP_W-1:0]     p_eff, cur_ext, nxt_ext;
  logic [IDX_W-1:0]     idx_start;
  logic [1:0]           n_use;
  logic [CFG_DATA_W-1:0] comp_sel;
  logic [31:0]          ucm;
  logic [15:0]          ph;
  logic [PP_W-1:0]      pos_prod;
  logic [POS_W-1:0]     pos;
  logic signed [18:0]   two_u;
  logic signed [RAW_W-1:0] shape_val;
  logic signed [33:0]   wprod;
  logic signed [ACC_W-1:0] acc_mag_s;
  logic [ACC_W-1:0]     acc_mag;
  logic signed [RAW_W-1:0] qs;
  logic signed [44:0]   m1_ext, prod;
  logic signed [15:0]   code_s;
  logic                 out_free;

  always_comb begin
    p_eff = {{(CMP_W-PERIOD_W){1'b0}}, period_q};
    if (p_eff < CMP_W'(2)) begin
      p_eff = CMP_W'(2);
    end else if (p_eff > CMP_W'(MAX_POINTS)) begin
      p_eff = CMP_W'(MAX_POINTS);
    end
    idx_start = (in_i.restart || ({{(CMP_W-IDX_W){1'b0}}, idx_q} >= p_eff)) ? '0 : idx_q;
    cur_ext = {{(CMP_W-IDX_W){1'b0}}, cur_q};
    nxt_ext = cur_ext + 1'b1;
    n_use = (32'(count_q) > COMPONENTS) ? 2'(COMPONENTS) : count_q;
    case (comp_q)
      2'd0:    comp_sel = comp_a_q;
      2'd1:    comp_sel = comp_b_q;
      default: comp_sel = comp_c_q;
    endcase
    ucm = u_q * comp_sel[17:2];
    ph = uc_q + ((wave_type_q == WAVE_MIX) ? 16'd0 : phase_q);
    pos_prod = {{POS_W{1'b0}}, ph[13:0]} * PP_W'(COS_TABLE_DEPTH);
    pos = pos_prod[PP_W-1:14];
    two_u = $signed({2'b00, uc_q, 1'b0});
    case (shape_q)
      SHAPE_TRI: begin
        if (uc_q < 16'd16384) begin
          shape_val = two_u[RAW_W-1:0];
        end else if (uc_q < 16'd49152) begin
          shape_val = RAW_W'(19'sd65536 - two_u);
        end else begin
          shape_val = RAW_W'(two_u - 19'sd131072);
        end
      end
      SHAPE_SQR: shape_val = uc_q[15] ? -17'sd32768 : 17'sd32768;
      SHAPE_SAW: shape_val = $signed({1'b0, uc_q}) - 17'sd32768;
      default: begin
        if (quad_q == 2'd1 || quad_q == 2'd2) begin
          shape_val = -$signed({1'b0, tdata_q});
        end else begin
          shape_val = $signed({1'b0, tdata_q});
        end
      end
    endcase
    wprod = raw_q * $signed({1'b0, comp_sel[33:18]});
    acc_mag_s = acc_q[ACC_W-1] ? -acc_q : acc_q;
    acc_mag = acc_mag_s;
    qs = $signed(div_quo);
    m1_ext = {{11{m1_q[33]}}, m1_q};
    prod = (m1_ext <<< 11) - m1_ext;
    code_s = {prod[44], prod[44:30]} + $signed({4'd0, CODE_MID});
    out_free = !ovalid_q || out_o.ready;
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    p_d      = p_q;
    u_d      = u_q;
    comp_d   = comp_q;
    shape_d  = shape_q;
    uc_d     = uc_q;
    quad_d   = quad_q;
    addr_d   = addr_q;
    tdata_d  = tdata_q;
    raw_d    = raw_q;
    acc_d    = acc_q;
    wsum_d   = wsum_q;
    m1_d     = m1_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ocode_d  = ocode_q;
    oend_d   = oend_q;
    div_start = 1'b0;
    div_num   = {{(DIV_NUM_W-IDX_W-16){1'b0}}, idx_start, 16'd0};
    div_den   = DIV_DEN_W'(p_eff);
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          div_start = 1'b1;
          cur_d   = idx_start;
          p_d     = p_eff;
          state_d = ST_UDIV;
        end
      end
      ST_UDIV: begin
        if (div_done) begin
          u_d = div_quo[15:0];
          comp_d = '0;
          acc_d  = '0;
          wsum_d = '0;
          if (wave_type_q == WAVE_MIX) begin
            if (n_use == 2'd0) begin
              raw_d   = '0;
              state_d = ST_SCALE;
            end else begin
              state_d = ST_CMUL;
            end
          end else begin
            uc_d    = div_quo[15:0];
            shape_d = (wave_type_q > WAVE_MIX) ? SHAPE_COS : wave_type_q[1:0];
            state_d = ST_ADDR;
          end
        end
      end
      ST_CMUL: begin
        uc_d    = ucm[23:8];
        shape_d = comp_sel[1:0];
        state_d = ST_ADDR;
      end
      ST_ADDR: begin
        quad_d  = ph[15:14];
        addr_d  = ph[14] ? POS_W'(COS_TABLE_DEPTH) - pos : pos;
        state_d = ST_ROM;
      end
      ST_ROM: begin
        tdata_d = cos_rom[addr_q];
        state_d = ST_RAW;
      end
      ST_RAW: begin
        raw_d   = shape_val;
        state_d = (wave_type_q == WAVE_MIX) ? ST_WMUL : ST_SCALE;
      end
      ST_WMUL: begin
        acc_d  = acc_q + ACC_W'(wprod);
        wsum_d = wsum_q + {2'b00, comp_sel[33:18]};
        if (comp_q + 1'b1 == n_use) begin
          state_d = ST_CFIN;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = ST_CMUL;
        end
      end
      ST_CFIN: begin
        if (wsum_q < WSUM_MIN) begin
          raw_d   = '0;
          state_d = ST_SCALE;
        end else begin
          div_start = 1'b1;
          div_num   = acc_mag[DIV_NUM_W-1:0];
          div_den   = wsum_q;
          state_d   = ST_CDIV;
        end
      end
      ST_CDIV: begin
        if (div_done) begin
          raw_d   = acc_q[ACC_W-1] ? -(qs + $signed(RAW_W'(div_rem_nz))) : qs;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        m1_d    = $signed({1'b0, amp_q}) * raw_q;
        state_d = ST_CODE;
      end
      ST_CODE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (code_s > $signed({4'd0, CODE_MAX})) begin
            ocode_d = CODE_MAX;
          end else if (code_s < $signed({4'd0, CODE_MIN})) begin
            ocode_d = CODE_MIN;
          end else begin
            ocode_d = code_s[CODE_W-1:0];
          end
          oend_d  = (nxt_ext == p_q);
          idx_d   = (nxt_ext >= p_q) ? '0 : IDX_W'(nxt_ext);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    p_q     <= p_d;
    u_q     <= u_d;
    comp_q  <= comp_d;
    shape_q <= shape_d;
    uc_q    <= uc_d;
    quad_q  <= quad_d;
    addr_q  <= addr_d;
    tdata_q <= tdata_d;
    raw_q   <= raw_d;
    acc_q   <= acc_d;
    wsum_q  <= wsum_d;
    m1_q    <= m1_d;
    ocode_q <= ocode_d;
    oend_q  <= oend_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = ovalid_q;
  assign out_o.dac_code   = ocode_q;
  assign out_o.period_end = oend_q;

endmodule
`default_nettype wire

/* rtl/core/msdwg_chk.sv */
// Port-level checks for the waveform generator, bound to the top level.
// Depends on multi_shape_dac_waveform_generator and msdwg_if.
`default_nettype none
module msdwg_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [11:0] dac_code_i
);

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (dac_code_i >= 12'd95 && dac_code_i <= 12'd4000))
    else $error("DAC code outside the safe margin.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("Input accepted while a transaction is still in work.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(dac_code_i)))
    else $error("Stalled output transaction changed.");

endmodule

bind multi_shape_dac_waveform_generator msdwg_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .dac_code_i  (out_o.dac_code)
);
`default_nettype wire

/* tb/sv/tb_multi_shape_dac_waveform_generator.sv */
// Self-checking testbench for the multi-shape DAC waveform generator.
// Drives update ticks with random idling and checks every DAC code against a local predictor.
// Depends on msdwg_pkg, msdwg_if and the top level of the generator.
`timescale 1ns / 1ps
module tb_multi_shape_dac_waveform_generator;
  import msdwg_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] dac_code;
    logic              period_end;
  } dac_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  msdwg_in_if  in_ch ();
  msdwg_out_if out_ch ();

  multi_shape_dac_waveform_generator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  logic              tick_q[$];
  dac_result_t       dac_expected_q[$];
  int                cos_quarter[0:COS_TABLE_DEPTH_DEF];
  logic [2:0]        m_wave;
  logic [10:0]       m_period;
  logic [15:0]       m_amp;
  logic [15:0]       m_phase;
  logic [1:0]        m_count;
  logic [33:0]       m_comp[3];
  int unsigned       m_index;
  bit                failed;
  bit                quiet;
  int                in_gap;
  int                out_stall;
  int                idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void build_cos_quarter();
    longint unsigned x, x2, term;
    longint sum;
    for (int k = 0; k <= COS_TABLE_DEPTH_DEF; k++) begin
      x    = (longint'(k) * HALF_PI_Q28) / COS_TABLE_DEPTH_DEF;
      x2   = (x * x) >> 28;
      term = 64'd1 << 28;
      sum  = longint'(term);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 28) / ((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      cos_quarter[k] = int'((sum + 4096) >>> 13);
    end
  endfunction

  function automatic int shape_value(logic [1:0] shp, int unsigned u, int unsigned ph);
    int unsigned p, pos;
    int v;
    v = int'(u);
    case (shp)
      SHAPE_TRI: begin
        if (u < 16384) return 2 * v;
        if (u < 49152) return 65536 - 2 * v;
        return 2 * v - 131072;
      end
      SHAPE_SQR: return (u < 32768) ? 32768 : -32768;
      SHAPE_SAW: return v - 32768;
      default: begin
        p   = (u + ph) & 16'hFFFF;
        pos = ((p & 16'h3FFF) * COS_TABLE_DEPTH_DEF) >> 14;
        case (p[15:14])
          2'd0: return cos_quarter[pos];
          2'd1: return -cos_quarter[COS_TABLE_DEPTH_DEF - pos];
          2'd2: return -cos_quarter[pos];
          default: return cos_quarter[COS_TABLE_DEPTH_DEF - pos];
        endcase
      end
    endcase
  endfunction

  function automatic int composite_value(int unsigned u);
    longint s, wsum, w;
    longint unsigned m;
    int unsigned uc;
    s    = 0;
    wsum = 0;
    for (int c = 0; c < int'(m_count); c++) begin
      m    = m_comp[c][17:2];
      w    = m_comp[c][33:18];
      uc   = int'(((longint'(u) * m) >> 8) & 16'hFFFF);
      s    = s + longint'(shape_value(m_comp[c][1:0], uc, 0)) * w;
      wsum = wsum + w;
    end
    if (wsum < WSUM_MIN) return 0;
    if (s >= 0) return int'(s / wsum);
    return int'(-((-s + wsum - 1) / wsum));
  endfunction

  function automatic dac_result_t predict_dac_code(logic restart);
    int unsigned p, u;
    int raw;
    longint prod, code;
    dac_result_t r;
    p = m_period;
    if (p < 2) p = 2;
    if (p > MAX_POINTS_DEF) p = MAX_POINTS_DEF;
    if (restart || m_index >= p) m_index = 0;
    u = int'((longint'(m_index) << 16) / p);
    if (m_wave == WAVE_MIX) begin
      raw = composite_value(u);
    end else if (m_wave > WAVE_MIX) begin
      raw = shape_value(SHAPE_COS, u, m_phase);
    end else begin
      raw = shape_value(m_wave[1:0], u, m_phase);
    end
    prod = 64'sd2047 * longint'(m_amp) * longint'(raw);
    code = (prod >>> 30) + 2048;
    if (code > longint'(CODE_MAX)) code = longint'(CODE_MAX);
    if (code < longint'(CODE_MIN)) code = longint'(CODE_MIN);
    r.dac_code   = code[CODE_W-1:0];
    r.period_end = (m_index == p - 1);
    m_index++;
    if (m_index >= p) m_index = 0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.restart <= 1'b0;
      in_gap        = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        dac_expected_q.push_back(predict_dac_code(in_ch.restart));
        void'(tick_q.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (!quiet && in_gap == 0 && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 9);
        end
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          in_ch.valid   <= 1'b1;
          in_ch.restart <= tick_q[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    dac_result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_stall    = 0;
      idle_cycles  = 0;
    end else begin
      idle_cycles++;
      if (in_ch.valid && in_ch.ready) idle_cycles = 0;
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        if (dac_expected_q.size() == 0) begin
          $display("%0t: unexpected transaction, actual code %0d period_end %0b",
                   $time, out_ch.dac_code, out_ch.period_end);
          failed = 1'b1;
        end else begin
          want = dac_expected_q.pop_front();
          if (out_ch.dac_code !== want.dac_code) begin
            $display("%0t: dac_code expected %0d actual %0d", $time, want.dac_code,
                     out_ch.dac_code);
            failed = 1'b1;
          end
          if (out_ch.period_end !== want.period_end) begin
            $display("%0t: period_end expected %0b actual %0b", $time, want.period_end,
                     out_ch.period_end);
            failed = 1'b1;
          end
        end
      end
      if (!quiet && out_stall == 0 && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(1, 9);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      if (idle_cycles >= 5000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_WAVE_TYPE:       m_wave   = data[2:0];
      REG_PERIOD_POINTS:   m_period = data[10:0];
      REG_AMPLITUDE:       m_amp    = data[15:0];
      REG_PHASE_TURN:      m_phase  = data[15:0];
      REG_COMPONENT_COUNT: m_count  = data[1:0];
      REG_COMPONENT_A:     m_comp[0] = data;
      REG_COMPONENT_B:     m_comp[1] = data;
      default:             m_comp[2] = data;
    endcase
  endtask

  task automatic apply_setting(logic [2:0] wave, logic [10:0] period, logic [15:0] amp,
                               logic [15:0] phase, logic [1:0] count, logic [33:0] ca,
                               logic [33:0] cb, logic [33:0] cc);
    write_reg(REG_WAVE_TYPE, CFG_DATA_W'(wave));
    write_reg(REG_PERIOD_POINTS, CFG_DATA_W'(period));
    write_reg(REG_AMPLITUDE, CFG_DATA_W'(amp));
    write_reg(REG_PHASE_TURN, CFG_DATA_W'(phase));
    write_reg(REG_COMPONENT_COUNT, CFG_DATA_W'(count));
    write_reg(REG_COMPONENT_A, ca);
    write_reg(REG_COMPONENT_B, cb);
    write_reg(REG_COMPONENT_C, cc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_ticks(int n, int restart_odds);
    for (int i = 0; i < n; i++) begin
      tick_q.push_back($urandom_range(0, restart_odds - 1) == 0);
    end
    while (tick_q.size() > 0 || dac_expected_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [33:0] rand_comp();
    return 34'({$urandom, $urandom});
  endfunction

  initial begin
    logic [10:0] per;
    failed     = 1'b0;
    quiet      = 1'b0;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    m_wave     = '0;
    m_period   = PERIOD_RESET;
    m_amp      = AMP_RESET;
    m_phase    = '0;
    m_count    = '0;
    m_comp     = '{default: '0};
    m_index    = 0;
    build_cos_quarter();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_ticks(4, 3);
    for (int w = 0; w < 5; w++) begin
      apply_setting(w[2:0], 11'd2, 16'd32768, 16'hFFFF, 2'd3, {16'hFFFF, 16'h0100, 2'd0},
                    {16'd0, 16'hFFFF, 2'd1}, {16'h8000, 16'h0300, 2'd3});
      run_ticks(3, 2);
    end
    apply_setting(3'd7, 11'd0, 16'hFFFF, 16'h4000, 2'd0, '0, '0, '0);
    run_ticks(3, 2);
    apply_setting(WAVE_MIX, 11'h7FF, 16'd0, 16'd0, 2'd0, 34'h3FFFFFFFF,
                  34'h3FFFFFFFF, 34'h3FFFFFFFF);
    run_ticks(2, 2);
    apply_setting(WAVE_MIX, 11'd8, 16'd32768, 16'd0, 2'd2, {16'd16, 16'h0100, 2'd2},
                  {16'd16, 16'h0200, 2'd1}, 34'h3FFFFFFFF);
    run_ticks(3, 2);

    for (int ph = 0; ph < 28; ph++) begin
      if (ph >= 22) quiet = 1'b1;
      per = ($urandom_range(0, 4) == 0) ? 11'($urandom) : 11'($urandom_range(2, 40));
      apply_setting(3'($urandom), per, ($urandom_range(0, 3) == 0) ? 16'd32768 : 16'($urandom),
                    16'($urandom), 2'($urandom), rand_comp(), rand_comp(), rand_comp());
      run_ticks(25, 20);
    end

    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/core/msdwg_pkg.sv
rtl/core/msdwg_if.sv
rtl/core/msdwg_div.sv
rtl/core/multi_shape_dac_waveform_generator.sv
rtl/core/msdwg_chk.sv
tb/sv/tb_multi_shape_dac_waveform_generator.sv
